// File: sv/assert_macros.svh
// Concurrent check helpers, clocked on i_clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_HOLDS(lbl, cond, msg)
`define CHK_IMPLIES(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/mlp_pkg.sv
package mlp_pkg;

    localparam int DEF_INPUT_COUNT = 16;
    localparam int DEF_HIDDEN_ONE  = 32;
    localparam int DEF_HIDDEN_TWO  = 16;
    localparam int DEF_CLASS_COUNT = 5;
    localparam int DEF_PARAM_DEPTH = 2048;

    localparam int EXP_STEPS   = 128;
    localparam int EXP_STEP_Q16 = 61565;

    typedef struct packed {
        logic               kind;
        logic [10:0]        weight_address;
        logic signed [15:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  class_index;
        logic [15:0] confidence;
        logic [3:0]  best_class;
        logic        unknown;
        logic        end_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN,
        ST_MAX,
        ST_EXP,
        ST_DIV,
        ST_EMIT,
        ST_UNKNOWN
    } t_state;

    typedef enum logic [1:0] {
        LAYER_ONE,
        LAYER_TWO,
        LAYER_THREE
    } t_layer;

    // exp(-k/16) in Q1.16, k = 0..128, built by repeated rounded multiply
    typedef logic [16:0] t_exp_lut [0:EXP_STEPS];

    function automatic t_exp_lut build_exp_lut();
        t_exp_lut   lut;
        logic [63:0] e;
        e = 64'd65536;
        for (int k = 0; k <= EXP_STEPS; k++) begin
            lut[k] = e[16:0];
            e = (e * 64'(EXP_STEP_Q16) + 64'd32768) >> 16;
        end
        return lut;
    endfunction

    localparam t_exp_lut EXP_LUT = build_exp_lut();

endpackage

// File: sv/mlp_classifier_inference_core.sv
// Channel    | Ports                               | Transfer
// -----------+-------------------------------------+--------------------------------
// item in    | start, busy, i_item                 | start high while busy low
// result out | o_valid, o_result                   | one cycle per strobe, no stall
//
// A weight word or a non-final feature is stored while the core stays idle. A final
// feature runs the network: one parameter read (biases plus weights) per cycle
// through the single parameter memory port, a short drain per layer, then a max
// pass, an exp pass and the bit-serial softmax divider over the classes, then one
// result per cycle. Reset is synchronous and clears control state only; the
// memories start undefined. busy stays high until the last result.
`include "assert_macros.svh"

module mlp_classifier_inference_core #(
    parameter int INPUT_COUNT = mlp_pkg::DEF_INPUT_COUNT,
    parameter int HIDDEN_ONE  = mlp_pkg::DEF_HIDDEN_ONE,
    parameter int HIDDEN_TWO  = mlp_pkg::DEF_HIDDEN_TWO,
    parameter int CLASS_COUNT = mlp_pkg::DEF_CLASS_COUNT,
    parameter int PARAM_DEPTH = mlp_pkg::DEF_PARAM_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mlp_pkg::t_in_item  i_item,
    output logic               o_valid,
    output mlp_pkg::t_out_item o_result
);

    // parameter layout
    localparam int W1_BASE    = 0;
    localparam int B1_BASE    = W1_BASE + INPUT_COUNT * HIDDEN_ONE;
    localparam int W2_BASE    = B1_BASE + HIDDEN_ONE;
    localparam int B2_BASE    = W2_BASE + HIDDEN_ONE * HIDDEN_TWO;
    localparam int W3_BASE    = B2_BASE + HIDDEN_TWO;
    localparam int B3_BASE    = W3_BASE + HIDDEN_TWO * CLASS_COUNT;
    localparam int LAYOUT_END = B3_BASE + CLASS_COUNT;
    localparam int LW  = $clog2(LAYOUT_END + 1);
    localparam int PAW = $clog2(PARAM_DEPTH);
    localparam int RW  = (LW > PAW) ? LW : PAW;
    localparam int WAW = (PAW > 11) ? PAW : 11;

    // activation memory: features, first hidden, second hidden
    localparam int ACT_DEPTH = INPUT_COUNT + HIDDEN_ONE + HIDDEN_TWO;
    localparam int AAW = $clog2(ACT_DEPTH);
    localparam int H1_BASE = INPUT_COUNT;
    localparam int H2_BASE = INPUT_COUNT + HIDDEN_ONE;

    localparam int MAX_A = (INPUT_COUNT > HIDDEN_ONE) ? INPUT_COUNT : HIDDEN_ONE;
    localparam int MAX_B = (HIDDEN_TWO > CLASS_COUNT) ? HIDDEN_TWO : CLASS_COUNT;
    localparam int MAXN  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int NW    = $clog2(MAXN + 1);
    localparam int CIW   = $clog2(CLASS_COUNT);
    localparam int FCW   = $clog2(INPUT_COUNT + 1);
    localparam int SW    = $clog2(CLASS_COUNT * 65536 + 1);

    mlp_pkg::t_state r_state, n_state;
    mlp_pkg::t_layer r_layer;

    logic [15:0]        param_mem [PARAM_DEPTH];
    logic signed [15:0] act_mem   [ACT_DEPTH];
    logic signed [15:0] r_score   [CLASS_COUNT];
    logic [16:0]        r_e       [CLASS_COUNT];
    logic [15:0]        r_conf    [CLASS_COUNT];

    logic           r_ready;
    logic [FCW-1:0] r_fcnt;
    logic [FCW-1:0] r_vlen;

    // issue counters
    logic [NW-1:0] r_i, r_j;
    logic          r_bias;
    logic [RW-1:0] r_wp;

    // MAC pipeline
    logic               r_a_v, r_a_first, r_a_last, r_a_pz, r_a_xz;
    logic [NW-1:0]      r_a_j;
    logic [15:0]        r_pdat;
    logic signed [15:0] r_adat;
    logic               r_b_v, r_b_first, r_b_last;
    logic [NW-1:0]      r_b_j;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_acc;

    // softmax
    logic [CIW-1:0]     r_k;
    logic signed [15:0] r_max;
    logic [SW-1:0]      r_sum;
    logic [32:0]        r_dnum;
    logic [SW-1:0]      r_rem;
    logic [32:0]        r_q;
    logic [5:0]         r_dstep;
    logic [CIW-1:0]     r_best;
    logic [15:0]        r_bconf;

    logic accept;
    assign accept = start && !busy;

    // layer geometry
    logic [NW-1:0]  l_nin, l_nout;
    logic [RW-1:0]  l_wbase, l_bbase;
    logic [AAW-1:0] l_inb, l_outb;
    always_comb begin
        unique case (r_layer)
            mlp_pkg::LAYER_ONE: begin
                l_nin = NW'(INPUT_COUNT);  l_nout = NW'(HIDDEN_ONE);
                l_wbase = RW'(W1_BASE);   l_bbase = RW'(B1_BASE);
                l_inb = AAW'(0);          l_outb = AAW'(H1_BASE);
            end
            mlp_pkg::LAYER_TWO: begin
                l_nin = NW'(HIDDEN_ONE);   l_nout = NW'(HIDDEN_TWO);
                l_wbase = RW'(W2_BASE);   l_bbase = RW'(B2_BASE);
                l_inb = AAW'(H1_BASE);    l_outb = AAW'(H2_BASE);
            end
            mlp_pkg::LAYER_THREE: begin
                l_nin = NW'(HIDDEN_TWO);   l_nout = NW'(CLASS_COUNT);
                l_wbase = RW'(W3_BASE);   l_bbase = RW'(B3_BASE);
                l_inb = AAW'(H2_BASE);    l_outb = AAW'(H2_BASE);
            end
            default: begin
                l_nin = NW'(INPUT_COUNT);  l_nout = NW'(HIDDEN_ONE);
                l_wbase = RW'(W1_BASE);   l_bbase = RW'(B1_BASE);
                l_inb = AAW'(0);          l_outb = AAW'(H1_BASE);
            end
        endcase
    end

    // issue-side addressing
    logic           issue_v, last_w, iss_pz, iss_xz;
    logic [RW-1:0]  iss_paddr;
    logic [AAW-1:0] iss_aaddr;
    assign issue_v   = (r_state == mlp_pkg::ST_ISSUE);
    assign last_w    = !r_bias && (r_i == l_nin - NW'(1));
    assign iss_paddr = r_bias ? (l_bbase + RW'(r_j)) : r_wp;
    assign iss_pz    = !({1'b0, iss_paddr} < (RW + 1)'(PARAM_DEPTH));
    assign iss_aaddr = l_inb + AAW'(r_i);
    assign iss_xz    = (r_layer == mlp_pkg::LAYER_ONE) && (32'(r_i) >= 32'(r_vlen));

    // neuron finish: floor shift, saturate, rectify in the hidden layers
    logic signed [31:0] n_acc;
    logic signed [19:0] fin_sh;
    logic signed [15:0] fin;
    always_comb begin
        n_acc  = r_b_first ? r_prod : (r_acc + r_prod);
        fin_sh = 20'(n_acc >>> 12);
        if (fin_sh > 20'sd32767)       fin = 16'sd32767;
        else if (fin_sh < -20'sd32768) fin = -16'sd32768;
        else                           fin = fin_sh[15:0];
        if (r_layer != mlp_pkg::LAYER_THREE && fin < 0) fin = 16'sd0;
    end

    // softmax helpers
    logic signed [15:0] cur_score;
    logic signed [16:0] sdiff;
    logic [7:0]         lut_idx;
    logic [16:0]        e_val;
    logic [16:0]        neg_d;
    logic [SW:0]        rem_sh;
    logic               qbit;
    logic [32:0]        q_fin;
    logic [15:0]        conf_fin;
    always_comb begin
        cur_score = r_score[r_k];
        sdiff     = 17'(cur_score) - 17'(r_max);
        neg_d     = 17'(-sdiff);
        lut_idx   = (sdiff < -17'sd32768) ? 8'(mlp_pkg::EXP_STEPS) : neg_d[15:8];
        e_val     = mlp_pkg::EXP_LUT[lut_idx];
        rem_sh    = {r_rem, r_dnum[32]};
        qbit      = (rem_sh >= {1'b0, r_sum});
        q_fin     = {r_q[31:0], qbit};
        conf_fin  = (q_fin > 33'd65535) ? 16'hFFFF : q_fin[15:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlp_pkg::ST_IDLE:
                if (accept && i_item.kind && i_item.last)
                    n_state = r_ready ? mlp_pkg::ST_SETUP : mlp_pkg::ST_UNKNOWN;
            mlp_pkg::ST_SETUP: n_state = mlp_pkg::ST_ISSUE;
            mlp_pkg::ST_ISSUE:
                if (last_w && r_j == l_nout - NW'(1)) n_state = mlp_pkg::ST_DRAIN;
            mlp_pkg::ST_DRAIN:
                if (!r_a_v && !r_b_v)
                    n_state = (r_layer == mlp_pkg::LAYER_THREE) ? mlp_pkg::ST_MAX
                                                                 : mlp_pkg::ST_SETUP;
            mlp_pkg::ST_MAX:
                if (r_k == CIW'(CLASS_COUNT - 1)) n_state = mlp_pkg::ST_EXP;
            mlp_pkg::ST_EXP:
                if (r_k == CIW'(CLASS_COUNT - 1)) n_state = mlp_pkg::ST_DIV;
            mlp_pkg::ST_DIV:
                if (r_dstep == 6'd33 && r_k == CIW'(CLASS_COUNT - 1))
                    n_state = mlp_pkg::ST_EMIT;
            mlp_pkg::ST_EMIT:
                if (r_k == CIW'(CLASS_COUNT - 1)) n_state = mlp_pkg::ST_IDLE;
            mlp_pkg::ST_UNKNOWN: n_state = mlp_pkg::ST_IDLE;
            default: n_state = mlp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy     = (r_state != mlp_pkg::ST_IDLE);
        o_valid  = 1'b0;
        o_result = '0;
        unique case (r_state)
            mlp_pkg::ST_EMIT: begin
                o_valid              = 1'b1;
                o_result.class_index = 4'(r_k);
                o_result.confidence  = r_conf[r_k];
                o_result.best_class  = 4'(r_best);
                o_result.end_of_run  = (r_k == CIW'(CLASS_COUNT - 1));
            end
            mlp_pkg::ST_UNKNOWN: begin
                o_valid             = 1'b1;
                o_result.unknown    = 1'b1;
                o_result.end_of_run = 1'b1;
            end
            default: ;
        endcase
    end

    // state, load flag, feature count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlp_pkg::ST_IDLE;
            r_ready <= 1'b0;
            r_fcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (accept && !i_item.kind && i_item.last) r_ready <= 1'b1;
            if (accept && i_item.kind) begin
                if (i_item.last)                            r_fcnt <= '0;
                else if (32'(r_fcnt) < INPUT_COUNT)         r_fcnt <= r_fcnt + FCW'(1);
            end
        end
    end

    // parameter memory
    logic [WAW-1:0] wr_wide;
    assign wr_wide = WAW'(i_item.weight_address);
    always_ff @(posedge i_clk) begin
        if (accept && !i_item.kind && (32'(wr_wide) < PARAM_DEPTH))
            param_mem[wr_wide[PAW-1:0]] <= i_item.value;
        r_pdat <= param_mem[iss_paddr[PAW-1:0]];
    end

    // activation memory: feature fill or neuron writeback
    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind && (32'(r_fcnt) < INPUT_COUNT))
            act_mem[AAW'(r_fcnt)] <= i_item.value;
        else if (r_b_v && r_b_last && r_layer != mlp_pkg::LAYER_THREE)
            act_mem[l_outb + AAW'(r_b_j)] <= fin;
        r_adat <= act_mem[iss_aaddr];
    end

    // control of layers and MAC pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= mlp_pkg::LAYER_ONE;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
        end else begin
            r_a_v <= issue_v;
            r_b_v <= r_a_v;
            if (r_state == mlp_pkg::ST_IDLE && accept && i_item.kind && i_item.last)
                r_layer <= mlp_pkg::LAYER_ONE;
            else if (r_state == mlp_pkg::ST_DRAIN && !r_a_v && !r_b_v) begin
                unique case (r_layer)
                    mlp_pkg::LAYER_ONE: r_layer <= mlp_pkg::LAYER_TWO;
                    mlp_pkg::LAYER_TWO: r_layer <= mlp_pkg::LAYER_THREE;
                    default:            r_layer <= r_layer;
                endcase
            end
        end
    end

    // vector length, issue counters, datapath
    always_ff @(posedge i_clk) begin
        if (r_state == mlp_pkg::ST_IDLE && accept && i_item.kind && i_item.last)
            r_vlen <= (32'(r_fcnt) < INPUT_COUNT) ? r_fcnt + FCW'(1) : r_fcnt;

        // advance issue
        if (r_state == mlp_pkg::ST_SETUP) begin
            r_wp   <= l_wbase;
            r_j    <= '0;
            r_i    <= '0;
            r_bias <= 1'b1;
        end else if (issue_v) begin
            if (r_bias) begin
                r_bias <= 1'b0;
                r_i    <= '0;
            end else begin
                r_wp <= r_wp + RW'(1);
                if (last_w) begin
                    r_bias <= 1'b1;
                    r_j    <= r_j + NW'(1);
                end else begin
                    r_i <= r_i + NW'(1);
                end
            end
        end

        // stage A tags
        r_a_first <= r_bias;
        r_a_last  <= last_w;
        r_a_pz    <= iss_pz;
        r_a_xz    <= iss_xz;
        r_a_j     <= r_j;

        // stage B: product or scaled bias
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_j     <= r_a_j;
        if (r_a_first)
            r_prod <= r_a_pz ? 32'sd0 : (32'(signed'(r_pdat)) <<< 12);
        else
            r_prod <= (r_a_pz || r_a_xz) ? 32'sd0
                    : 32'(signed'(r_pdat)) * 32'(r_adat);

        // stage C: accumulate and write back
        if (r_b_v) begin
            r_acc <= n_acc;
            if (r_b_last && r_layer == mlp_pkg::LAYER_THREE)
                r_score[r_b_j[CIW-1:0]] <= fin;
        end

        // softmax sequencing
        unique case (r_state)
            mlp_pkg::ST_DRAIN: r_k <= '0;
            mlp_pkg::ST_MAX: begin
                if (r_k == '0 || cur_score > r_max) r_max <= cur_score;
                r_k <= (r_k == CIW'(CLASS_COUNT - 1)) ? '0 : r_k + CIW'(1);
            end
            mlp_pkg::ST_EXP: begin
                r_e[r_k] <= e_val;
                r_sum    <= ((r_k == '0) ? '0 : r_sum) + SW'(e_val);
                r_dstep  <= '0;
                r_k      <= (r_k == CIW'(CLASS_COUNT - 1)) ? '0 : r_k + CIW'(1);
            end
            mlp_pkg::ST_DIV: begin
                if (r_dstep == 6'd0) begin
                    r_dnum  <= {r_e[r_k], 16'h0000};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dstep <= 6'd1;
                end else begin
                    r_rem   <= qbit ? SW'(rem_sh - {1'b0, r_sum}) : rem_sh[SW-1:0];
                    r_q     <= q_fin;
                    r_dnum  <= {r_dnum[31:0], 1'b0};
                    if (r_dstep == 6'd33) begin
                        r_conf[r_k] <= conf_fin;
                        if (r_k == '0 || conf_fin > r_bconf) begin
                            r_best  <= r_k;
                            r_bconf <= conf_fin;
                        end
                        r_dstep <= 6'd0;
                        r_k <= (r_k == CIW'(CLASS_COUNT - 1)) ? '0 : r_k + CIW'(1);
                    end else begin
                        r_dstep <= r_dstep + 6'd1;
                    end
                end
            end
            mlp_pkg::ST_EMIT: r_k <= r_k + CIW'(1);
            default: ;
        endcase
    end

    // checks
    `CHK_IMPLIES(a_strobe_busy, o_valid, busy, "result strobe while idle")
    `CHK_NEXT(a_end_idle, o_valid && o_result.end_of_run, r_state == mlp_pkg::ST_IDLE, "not idle after run")
    `CHK_IMPLIES(a_mac_in_layer, r_b_v, r_state == mlp_pkg::ST_ISSUE || r_state == mlp_pkg::ST_DRAIN, "MAC outside layer")
    `CHK_IMPLIES(a_unknown_only_unloaded, o_valid && o_result.unknown, !r_ready, "unknown with loaded net")

endmodule

// File: test/mlp_classifier_inference_core_tb.sv
module mlp_classifier_inference_core_tb;

    localparam int N_IN   = mlp_pkg::DEF_INPUT_COUNT;
    localparam int N_H1   = mlp_pkg::DEF_HIDDEN_ONE;
    localparam int N_H2   = mlp_pkg::DEF_HIDDEN_TWO;
    localparam int N_CLS  = mlp_pkg::DEF_CLASS_COUNT;
    localparam int DEPTH  = mlp_pkg::DEF_PARAM_DEPTH;
    localparam int W1_AT  = 0;
    localparam int B1_AT  = W1_AT + N_IN * N_H1;
    localparam int W2_AT  = B1_AT + N_H1;
    localparam int B2_AT  = W2_AT + N_H1 * N_H2;
    localparam int W3_AT  = B2_AT + N_H2;
    localparam int B3_AT  = W3_AT + N_H2 * N_CLS;
    localparam int PARAM_USED  = B3_AT + N_CLS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    mlp_pkg::t_in_item  i_item;
    logic               o_valid;
    mlp_pkg::t_out_item o_result;

    mlp_classifier_inference_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // predictor state
    logic signed [15:0] weight_mem [0:DEPTH-1];
    int                 feature_vec [0:N_IN-1];
    int                 feature_fill;
    bit                 net_loaded;
    int                 act_in  [0:N_H1-1];
    int                 act_out [0:N_H1-1];
    mlp_pkg::t_out_item pending_results[$];
    int                 err_count;
    int                 cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // one dense layer from act_in into act_out
    task automatic run_layer(int n_in, int n_out, int w_at, int b_at, bit rect);
        bit [31:0] acc;
        int        s;
        for (int j = 0; j < n_out; j++) begin
            acc = 32'(int'(weight_mem[b_at + j])) << 12;
            for (int i = 0; i < n_in; i++)
                acc += 32'(act_in[i] * int'(weight_mem[w_at + j * n_in + i]));
            s = int'(acc) >>> 12;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            if (rect && s < 0) s = 0;
            act_out[j] = s;
        end
        for (int j = 0; j < n_out; j++) act_in[j] = act_out[j];
    endtask

    // classify the collected features and queue one result per class
    task automatic classify_features();
        int                 top, d, steps, best;
        longint             ex [0:N_CLS-1];
        longint             conf [0:N_CLS-1];
        longint             total;
        mlp_pkg::t_out_item r;
        for (int i = 0; i < N_IN; i++) act_in[i] = feature_vec[i];
        run_layer(N_IN, N_H1, W1_AT, B1_AT, 1'b1);
        run_layer(N_H1, N_H2, W2_AT, B2_AT, 1'b1);
        run_layer(N_H2, N_CLS, W3_AT, B3_AT, 1'b0);
        top = act_in[0];
        for (int k = 1; k < N_CLS; k++) if (act_in[k] > top) top = act_in[k];
        total = 0;
        for (int k = 0; k < N_CLS; k++) begin
            d = act_in[k] - top;
            if (d < -32768) d = -32768;
            steps = (-d) >> 8;
            ex[k] = 65536;
            for (int s = 0; s < steps && s < mlp_pkg::EXP_STEPS; s++)
                ex[k] = (ex[k] * mlp_pkg::EXP_STEP_Q16 + 32768) >> 16;
            total += ex[k];
        end
        best = 0;
        for (int k = 0; k < N_CLS; k++) begin
            conf[k] = (ex[k] << 16) / total;
            if (conf[k] > 65535) conf[k] = 65535;
            if (conf[k] > conf[best]) best = k;
        end
        for (int k = 0; k < N_CLS; k++) begin
            r.class_index = 4'(k);
            r.confidence  = 16'(conf[k]);
            r.best_class  = 4'(best);
            r.unknown     = 1'b0;
            r.end_of_run  = (k == N_CLS - 1);
            pending_results.push_back(r);
        end
    endtask

    // update the predictor for one accepted transaction
    task automatic predict_item(mlp_pkg::t_in_item it);
        mlp_pkg::t_out_item r;
        if (it.kind == KIND_WEIGHT) begin
            weight_mem[it.weight_address] = it.value;
            if (it.last) net_loaded = 1'b1;
            return;
        end
        if (feature_fill < N_IN) begin
            feature_vec[feature_fill] = int'(it.value);
            feature_fill++;
        end
        if (!it.last) return;
        for (int k = feature_fill; k < N_IN; k++) feature_vec[k] = 0;
        feature_fill = 0;
        if (!net_loaded) begin
            r = '0;
            r.unknown    = 1'b1;
            r.end_of_run = 1'b1;
            pending_results.push_back(r);
        end else begin
            classify_features();
        end
    endtask

    // send one transaction after a random gap; start stays high for the caller
    task automatic send_item(logic kind, int addr, int value, logic last);
        int gap;
        mlp_pkg::t_in_item it;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.kind           = kind;
        it.weight_address = 11'(addr);
        it.value          = 16'(value);
        it.last           = last;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_item(it);
    endtask

    // lower start and wait until every result has come
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic int pick_value(bit wide);
        case ($urandom_range(0, 9))
            0: return wide ? -32768 : -1024;
            1: return wide ? 32767 : 1023;
            2: return int'($urandom_range(0, 65535)) - 32768;
            default: return wide ? int'($urandom_range(0, 65535)) - 32768
                                 : int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    task automatic send_vector(int len, bit wide);
        for (int i = 0; i < len; i++)
            send_item(KIND_FEATURE, $urandom_range(0, 2047), pick_value(wide), i == len - 1);
    endtask

    task automatic load_network(bit wide);
        for (int a = 0; a < PARAM_USED; a++)
            send_item(KIND_WEIGHT, a, pick_value(wide), a == PARAM_USED - 1);
        wait_idle();
    endtask

    // vectors before any load give the unknown result
    task automatic test_unloaded();
        send_vector(N_IN, 1'b0);
        send_vector(1, 1'b0);
        send_vector(N_IN + 4, 1'b1);
        send_item(KIND_WEIGHT, 2047, 32767, 1'b0);
        send_item(KIND_WEIGHT, 1500, -32768, 1'b0);
        send_vector(3, 1'b0);
        wait_idle();
    endtask

    // full, short, long and extreme vectors on a small-weight network
    task automatic test_directed_vectors();
        load_network(1'b0);
        send_vector(N_IN, 1'b0);
        send_vector(1, 1'b0);
        send_vector(N_IN + 3, 1'b0);
        for (int i = 0; i < N_IN; i++)
            send_item(KIND_FEATURE, 0, (i % 2) ? 32767 : -32768, i == N_IN - 1);
        for (int i = 0; i < N_IN; i++)
            send_item(KIND_FEATURE, 0, 32767, i == N_IN - 1);
        wait_idle();
    endtask

    // mostly well-formed vectors, with weight rewrites and stray features
    task automatic test_random_traffic(int item_goal, bit wide);
        int sent, len;
        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    send_item(KIND_WEIGHT, $urandom_range(0, 2047),
                              pick_value(1'b1), 1'($urandom_range(0, 1)));
                    sent++;
                end
                2: begin
                    send_vector(1, 1'b1);
                    sent++;
                end
                default: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, N_IN + 4) : N_IN;
                    send_vector(len, wide);
                    sent += len;
                end
            endcase
        end
        wait_idle();
    endtask

    // rewrite part of the network with full-range words to push saturation
    task automatic test_saturating_network();
        for (int n = 0; n < 24; n++)
            send_item(KIND_WEIGHT, $urandom_range(0, PARAM_USED - 1), pick_value(1'b1), 1'b0);
        test_random_traffic(40, 1'b1);
    endtask

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.class_index, -1);
            end else begin
                mlp_pkg::t_out_item w;
                w = pending_results.pop_front();
                if (o_result.class_index !== w.class_index)
                    report_mismatch("class_index", o_result.class_index, w.class_index);
                if (o_result.confidence !== w.confidence)
                    report_mismatch("confidence", o_result.confidence, w.confidence);
                if (o_result.best_class !== w.best_class)
                    report_mismatch("best_class", o_result.best_class, w.best_class);
                if (o_result.unknown !== w.unknown)
                    report_mismatch("unknown", o_result.unknown, w.unknown);
                if (o_result.end_of_run !== w.end_of_run)
                    report_mismatch("end_of_run", o_result.end_of_run, w.end_of_run);
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        err_count    = 0;
        cycle_count  = 0;
        feature_fill = 0;
        net_loaded   = 1'b0;
        for (int i = 0; i < N_IN; i++) feature_vec[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unloaded();
        test_directed_vectors();
        test_random_traffic(130, 1'b0);
        test_saturating_network();

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
